/* design/mesi_pkg.sv */
// Shared constants, types and helper functions of the MESI L1 tag and snoop controller.
package mesi_pkg;

	localparam int LINE_BYTES = 64;
	localparam int NUM_SETS   = 64;
	localparam int NUM_WAYS   = 4;
	localparam int ADDR_BITS  = 32;

	localparam int OFF_BITS = $clog2(LINE_BYTES);
	localparam int IDX_BITS = $clog2(NUM_SETS);
	localparam int TAG_BITS = ADDR_BITS - OFF_BITS - IDX_BITS;
	localparam int WAY_BITS = $clog2(NUM_WAYS);

	typedef logic [1:0]          req_t;
	typedef logic [1:0]          mesi_t;
	typedef logic [WAY_BITS-1:0] way_t;
	typedef logic [IDX_BITS-1:0] set_t;
	typedef logic [TAG_BITS-1:0] tag_t;

	localparam req_t REQ_FILL  = 2'd0;
	localparam req_t REQ_READ  = 2'd1;
	localparam req_t REQ_INVAL = 2'd2;
	localparam req_t REQ_OTHER = 2'd3;

	localparam mesi_t ST_INVALID   = 2'd0;
	localparam mesi_t ST_SHARED    = 2'd1;
	localparam mesi_t ST_EXCLUSIVE = 2'd2;
	localparam mesi_t ST_MODIFIED  = 2'd3;

	// LRU order of one set: entry 0 is the least recently used way.
	typedef way_t [NUM_WAYS-1:0] lru_t;

	typedef struct packed {
		tag_t  [NUM_WAYS-1:0] tags;
		mesi_t [NUM_WAYS-1:0] states;
		lru_t                 lru;
	} meta_row_t;

	// Order after reset: way 0 least recent, last way most recent.
	function automatic lru_t lru_reset_order();
		lru_t o;
		for (int i = 0; i < NUM_WAYS; i++) begin
			o[i] = way_t'(i);
		end
		return o;
	endfunction

	// Moves the given way to the most recent end, shifting the later entries down.
	function automatic lru_t lru_touch(lru_t order, way_t way);
		lru_t            o;
		logic [NUM_WAYS-1:0] at_or_after;
		logic            seen;
		seen = 1'b0;
		for (int i = 0; i < NUM_WAYS; i++) begin
			seen           = seen | (order[i] == way);
			at_or_after[i] = seen;
		end
		for (int i = 0; i < NUM_WAYS - 1; i++) begin
			o[i] = at_or_after[i] ? order[i+1] : order[i];
		end
		o[NUM_WAYS-1] = way;
		return o;
	endfunction

endpackage

/* design/mesi_l1_tag_snoop_controller_top.sv */
// Top level of the MESI L1 tag and snoop controller: metadata memory, lookup and update.
// A request taken at a clock edge is registered in stage 1 with its memory row; its result then
// passes through the result register and is shown with done high.
// Throughput: one request per cycle; busy stays low, as a set is read, updated and written
// back in one pass and a same-set follower is served by a bypass.
// Reset clears the per-set row valid bits (lines Invalid, LRU 0,1,2,3); results cannot stall.
module mesi_l1_tag_snoop_controller_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  mesi_pkg::req_t        req_type,
	input  logic [31:0]           line_addr,
	input  logic                  fill_shared,
	output logic                  done,
	output logic                  has_line,
	output logic                  was_modified,
	output logic                  shared_hit,
	output logic [1:0]            way_used,
	output logic                  data_write,
	output logic                  flush_valid,
	output logic [31:0]           flush_addr,
	output logic [1:0]            new_state
);

	localparam int OFF = mesi_pkg::OFF_BITS;
	localparam int IDX = mesi_pkg::IDX_BITS;
	localparam int NW  = mesi_pkg::NUM_WAYS;

	// Every request is taken as it arrives; the pipeline never stalls.
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	mesi_pkg::set_t set_in;
	assign set_in = line_addr[OFF+IDX-1:OFF];

	// One row per set holds the tags, the MESI states and the LRU order of all ways.
	mesi_pkg::meta_row_t meta_mem [mesi_pkg::NUM_SETS];
	logic [mesi_pkg::NUM_SETS-1:0] row_valid_q;

	// Stage 1 registers: the request and the memory row read for it.
	logic                vld_s1;
	mesi_pkg::req_t      req_s1;
	logic [31:0]         addr_s1;
	logic                shared_s1;
	mesi_pkg::meta_row_t mem_rd_s1;
	logic                rv_s1;
	logic                byp_s1;
	mesi_pkg::meta_row_t byp_row_s1;

	// Write back of the updated row, computed from stage 1.
	logic                wr_en;
	mesi_pkg::set_t      wr_set;
	mesi_pkg::meta_row_t wr_row;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			meta_mem[wr_set] <= wr_row;
		end
		mem_rd_s1 <= meta_mem[set_in];
	end

	// When the previous request writes the same set at the edge that reads it, the
	// freshly written row is captured instead of the stale memory output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			rv_s1       <= 1'b0;
			byp_s1      <= 1'b0;
			row_valid_q <= '0;
		end else begin
			vld_s1 <= accept;
			rv_s1  <= row_valid_q[set_in];
			byp_s1 <= wr_en && (wr_set == set_in);
			if (wr_en) begin
				row_valid_q[wr_set] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		req_s1     <= req_type;
		addr_s1    <= line_addr;
		shared_s1  <= fill_shared;
		byp_row_s1 <= wr_row;
	end

	// Row as seen by this request: bypass first, then memory, then the reset view.
	mesi_pkg::meta_row_t row;
	always_comb begin
		if (byp_s1) begin
			row = byp_row_s1;
		end else if (rv_s1) begin
			row = mem_rd_s1;
		end else begin
			row        = mem_rd_s1;
			row.states = '0;
			row.lru    = mesi_pkg::lru_reset_order();
		end
	end

	mesi_pkg::set_t set_s1;
	mesi_pkg::tag_t tag_s1;
	assign set_s1 = addr_s1[OFF+IDX-1:OFF];
	assign tag_s1 = addr_s1[31:OFF+IDX];

	// Lowest-numbered Invalid way and lowest-numbered tag hit.
	logic          inv_found;
	mesi_pkg::way_t inv_way;
	logic          hit;
	mesi_pkg::way_t hit_way;
	always_comb begin
		inv_found = 1'b0;
		inv_way   = '0;
		hit       = 1'b0;
		hit_way   = '0;
		for (int w = NW - 1; w >= 0; w--) begin
			if (row.states[w] == mesi_pkg::ST_INVALID) begin
				inv_found = 1'b1;
				inv_way   = mesi_pkg::way_t'(w);
			end
			if (row.states[w] != mesi_pkg::ST_INVALID && row.tags[w] == tag_s1) begin
				hit     = 1'b1;
				hit_way = mesi_pkg::way_t'(w);
			end
		end
	end

	mesi_pkg::way_t victim;
	assign victim = inv_found ? inv_way : row.lru[0];

	// Result fields and the updated row.
	logic          r_has_line;
	logic          r_was_mod;
	logic          r_shared_hit;
	logic          r_data_write;
	logic          r_flush;
	logic [31:0]   r_flush_addr;
	mesi_pkg::way_t r_way;
	mesi_pkg::mesi_t r_state;
	logic          r_write;

	always_comb begin
		r_has_line   = 1'b0;
		r_was_mod    = 1'b0;
		r_shared_hit = 1'b0;
		r_data_write = 1'b0;
		r_flush      = 1'b0;
		r_flush_addr = '0;
		r_way        = '0;
		r_state      = mesi_pkg::ST_INVALID;
		r_write      = 1'b0;
		wr_row       = row;
		case (req_s1)
			mesi_pkg::REQ_FILL: begin
				// The victim is written back only when it holds dirty data.
				if (row.states[victim] == mesi_pkg::ST_MODIFIED) begin
					r_flush      = 1'b1;
					r_flush_addr = {row.tags[victim], set_s1, {OFF{1'b0}}};
				end
				wr_row.tags[victim]   = tag_s1;
				wr_row.states[victim] = shared_s1 ? mesi_pkg::ST_SHARED
				                                  : mesi_pkg::ST_EXCLUSIVE;
				wr_row.lru            = mesi_pkg::lru_touch(row.lru, victim);
				r_way        = victim;
				r_data_write = 1'b1;
				r_state      = wr_row.states[victim];
				r_write      = 1'b1;
			end
			default: begin
				// Snoops: a miss leaves everything zero and writes nothing back.
				if (hit) begin
					wr_row.lru = mesi_pkg::lru_touch(row.lru, hit_way);
					r_has_line = 1'b1;
					r_way      = hit_way;
					r_write    = 1'b1;
					if (req_s1 == mesi_pkg::REQ_READ) begin
						if (row.states[hit_way] == mesi_pkg::ST_MODIFIED) begin
							r_was_mod    = 1'b1;
							r_flush      = 1'b1;
							r_flush_addr = {addr_s1[31:OFF], {OFF{1'b0}}};
						end
						wr_row.states[hit_way] = mesi_pkg::ST_SHARED;
						r_shared_hit           = 1'b1;
					end else if (req_s1 == mesi_pkg::REQ_INVAL) begin
						wr_row.states[hit_way] = mesi_pkg::ST_INVALID;
					end
					r_state = wr_row.states[hit_way];
				end
			end
		endcase
	end

	assign wr_en  = vld_s1 && r_write;
	assign wr_set = set_s1;

	// Result register, strobed by done, which is high for a single cycle per result.
	logic          done_q;
	logic          has_line_q;
	logic          was_mod_q;
	logic          shared_hit_q;
	logic [1:0]    way_q;
	logic          data_write_q;
	logic          flush_q;
	logic [31:0]   flush_addr_q;
	logic [1:0]    state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			has_line_q   <= r_has_line;
			was_mod_q    <= r_was_mod;
			shared_hit_q <= r_shared_hit;
			way_q        <= 2'(r_way);
			data_write_q <= r_data_write;
			flush_q      <= r_flush;
			flush_addr_q <= r_flush_addr;
			state_q      <= r_state;
		end
	end

	assign done         = done_q;
	assign has_line     = has_line_q;
	assign was_modified = was_mod_q;
	assign shared_hit   = shared_hit_q;
	assign way_used     = way_q;
	assign data_write   = data_write_q;
	assign flush_valid  = flush_q;
	assign flush_addr   = flush_addr_q;
	assign new_state    = state_q;

endmodule

/* design/mesi_chk.sv */
// Port-level checker of the MESI L1 tag and snoop controller, bound to its top level.
module mesi_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        has_line,
	input logic        was_modified,
	input logic        shared_hit,
	input logic [1:0]  way_used,
	input logic        data_write,
	input logic        flush_valid,
	input logic [31:0] flush_addr,
	input logic [1:0]  new_state
);

	// Every accepted transfer yields its result after stage 1 and the result register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("accepted request produced no result");

	a_fill_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(done && data_write) |-> (!has_line && !was_modified && !shared_hit
			&& new_state != mesi_pkg::ST_INVALID))
		else $error("fill result carries snoop flags or an Invalid state");

	a_dirty_read: assert property (@(posedge clk) disable iff (!arst_n)
		(done && was_modified) |-> (flush_valid && shared_hit && has_line
			&& new_state == mesi_pkg::ST_SHARED))
		else $error("snooped Modified line not flushed and shared");

	a_miss_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !has_line && !data_write) |-> (!flush_valid && flush_addr == 32'd0
			&& new_state == mesi_pkg::ST_INVALID && way_used == 2'd0))
		else $error("snoop miss reported a nonzero field");

endmodule

bind mesi_l1_tag_snoop_controller_top mesi_chk u_mesi_chk (.*);

/* verif/tb_mesi_l1_tag_snoop_controller_top.sv */
// Self-checking testbench of the MESI L1 tag and snoop controller: directed and random bus events.
`timescale 1ns / 1ps

module tb_mesi_l1_tag_snoop_controller_top;

	// A watchdog ends the run after this many cycles in which no transfer happens at either side.
	localparam int QUIET_LIMIT  = 1000;
	localparam int RANDOM_COUNT = 450;
	// The block shows a result after stage 1 and the result register, which the tail outlasts.
	localparam int TAIL_CYCLES  = 8;

	// One bus event as the sender presents it. A drain event is held back until every
	// result already owed by the block has arrived.
	typedef struct {
		mesi_pkg::req_t req;
		logic [31:0]    addr;
		logic           shared;
		bit             drain;
	} bus_event_t;

	// Everything the block reports for one bus event.
	typedef struct packed {
		logic        has_line;
		logic        was_modified;
		logic        shared_hit;
		logic [1:0]  way_used;
		logic        data_write;
		logic        flush_valid;
		logic [31:0] flush_addr;
		logic [1:0]  new_state;
	} tag_outcome_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           start = 1'b0;
	mesi_pkg::req_t req_type = mesi_pkg::REQ_FILL;
	logic [31:0]    line_addr = '0;
	logic           fill_shared = 1'b0;
	logic           busy;
	logic           done;
	logic           has_line;
	logic           was_modified;
	logic           shared_hit;
	logic [1:0]     way_used;
	logic           data_write;
	logic           flush_valid;
	logic [31:0]    flush_addr;
	logic [1:0]     new_state;

	mesi_l1_tag_snoop_controller_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.line_addr    (line_addr),
		.fill_shared  (fill_shared),
		.done         (done),
		.has_line     (has_line),
		.was_modified (was_modified),
		.shared_hit   (shared_hit),
		.way_used     (way_used),
		.data_write   (data_write),
		.flush_valid  (flush_valid),
		.flush_addr   (flush_addr),
		.new_state    (new_state)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Our own copy of the cache metadata. Tags are left unknown after reset; they are only
	// looked at for lines that a fill has made valid.
	mesi_pkg::mesi_t line_mesi [mesi_pkg::NUM_SETS][mesi_pkg::NUM_WAYS];
	mesi_pkg::tag_t  line_tags [mesi_pkg::NUM_SETS][mesi_pkg::NUM_WAYS];
	// Per set, entry 0 holds the least recently used way and the last entry the most recent.
	mesi_pkg::way_t  lru_rank  [mesi_pkg::NUM_SETS][mesi_pkg::NUM_WAYS];

	bus_event_t   bus_events[$];
	tag_outcome_t owed_outcomes[$];
	bit           event_taken = 1'b0;
	int           events_sent = 0;
	int           quiet_cycles = 0;
	int           errors = 0;

	// Moves a way to the most recent end of its set's order; the later entries slide down.
	function automatic void make_most_recent(mesi_pkg::set_t s, mesi_pkg::way_t way);
		int pos;
		pos = mesi_pkg::NUM_WAYS - 1;
		for (int i = mesi_pkg::NUM_WAYS - 1; i >= 0; i--) begin
			if (lru_rank[s][i] == way)
				pos = i;
		end
		for (int i = pos; i < mesi_pkg::NUM_WAYS - 1; i++)
			lru_rank[s][i] = lru_rank[s][i + 1];
		lru_rank[s][mesi_pkg::NUM_WAYS - 1] = way;
	endfunction

	// Applies one bus event to the metadata copy and returns what the block must report.
	function automatic tag_outcome_t tag_update(mesi_pkg::req_t req, logic [31:0] addr,
		logic shared);
		tag_outcome_t   r;
		mesi_pkg::set_t s;
		mesi_pkg::tag_t t;
		mesi_pkg::way_t way;
		bit             found;
		r = '0;
		s = addr[mesi_pkg::OFF_BITS +: mesi_pkg::IDX_BITS];
		t = addr[mesi_pkg::OFF_BITS + mesi_pkg::IDX_BITS +: mesi_pkg::TAG_BITS];
		way = '0;
		found = 1'b0;
		if (req == mesi_pkg::REQ_FILL) begin
			// The lowest-numbered invalid way wins; with the set full, the LRU way is the victim.
			for (int w = mesi_pkg::NUM_WAYS - 1; w >= 0; w--) begin
				if (line_mesi[s][w] == mesi_pkg::ST_INVALID) begin
					way = mesi_pkg::way_t'(w);
					found = 1'b1;
				end
			end
			if (!found)
				way = lru_rank[s][0];
			// A dirty victim has to be written back under its own, rebuilt address.
			if (line_mesi[s][way] == mesi_pkg::ST_MODIFIED) begin
				r.flush_valid = 1'b1;
				r.flush_addr  = {line_tags[s][way], s, {mesi_pkg::OFF_BITS{1'b0}}};
			end
			line_tags[s][way] = t;
			line_mesi[s][way] = shared ? mesi_pkg::ST_SHARED : mesi_pkg::ST_EXCLUSIVE;
			make_most_recent(s, way);
			r.way_used   = way;
			r.data_write = 1'b1;
			r.new_state  = line_mesi[s][way];
			return r;
		end
		for (int w = mesi_pkg::NUM_WAYS - 1; w >= 0; w--) begin
			if (line_mesi[s][w] != mesi_pkg::ST_INVALID && line_tags[s][w] == t) begin
				way = mesi_pkg::way_t'(w);
				found = 1'b1;
			end
		end
		// A snoop miss reports nothing at all.
		if (!found)
			return r;
		make_most_recent(s, way);
		r.has_line = 1'b1;
		r.way_used = way;
		case (req)
			mesi_pkg::REQ_READ: begin
				// Another reader: a dirty copy supplies its data, and the line ends up Shared.
				if (line_mesi[s][way] == mesi_pkg::ST_MODIFIED) begin
					r.was_modified = 1'b1;
					r.flush_valid  = 1'b1;
					r.flush_addr   = {addr[31:mesi_pkg::OFF_BITS], {mesi_pkg::OFF_BITS{1'b0}}};
				end
				line_mesi[s][way] = mesi_pkg::ST_SHARED;
				r.shared_hit = 1'b1;
			end
			mesi_pkg::REQ_INVAL: begin
				line_mesi[s][way] = mesi_pkg::ST_INVALID;
			end
			default: begin
				// Any other snooped message only refreshes the LRU order.
			end
		endcase
		r.new_state = line_mesi[s][way];
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	function automatic logic [31:0] line_of(mesi_pkg::tag_t t, mesi_pkg::set_t s);
		return {t, s, {mesi_pkg::OFF_BITS{1'b0}}};
	endfunction

	function automatic void push_event(mesi_pkg::req_t req, logic [31:0] addr, logic shared,
		bit drain);
		bus_event_t e;
		e.req    = req;
		e.addr   = addr;
		e.shared = shared;
		e.drain  = drain;
		bus_events = {bus_events, e};
	endfunction

	// Sender. Inputs change at the falling edge only. A presented event stays on the ports
	// until the rising edge that takes it, unless the sender decides to idle for a while.
	// Events 180 to 299 are never idled by the sender, though a drain event among them still waits.
	always @(negedge clk) begin
		bit go;
		bit idle;
		if (event_taken) begin
			void'(bus_events.pop_front());
			events_sent++;
		end
		idle = ($urandom_range(0, 99) < 37) && !(events_sent >= 180 && events_sent < 300);
		go = arst_n && bus_events.size() != 0 && !idle
			&& !(bus_events[0].drain && owed_outcomes.size() != 0);
		if (go) begin
			start       <= 1'b1;
			req_type    <= bus_events[0].req;
			line_addr   <= bus_events[0].addr;
			fill_shared <= bus_events[0].shared;
		end else begin
			start <= 1'b0;
		end
	end

	// Monitor. At each rising edge it first checks a result that is on the ports, and only
	// then records a request taken at the same edge: a result can never belong to a request
	// of the same edge, since the block registers it in stage 1 and then in its result register.
	always @(posedge clk) begin
		tag_outcome_t got;
		tag_outcome_t want;
		if (arst_n) begin
			if (done) begin
				got = '{has_line, was_modified, shared_hit, way_used, data_write,
					flush_valid, flush_addr, new_state};
				if (owed_outcomes.size() == 0) begin
					$error("result with no request outstanding");
					errors++;
				end else begin
					want = owed_outcomes.pop_front();
					check_field("has_line", 32'(want.has_line), 32'(got.has_line));
					check_field("was_modified", 32'(want.was_modified), 32'(got.was_modified));
					check_field("shared_hit", 32'(want.shared_hit), 32'(got.shared_hit));
					check_field("way_used", 32'(want.way_used), 32'(got.way_used));
					check_field("data_write", 32'(want.data_write), 32'(got.data_write));
					check_field("flush_valid", 32'(want.flush_valid), 32'(got.flush_valid));
					check_field("flush_addr", want.flush_addr, got.flush_addr);
					check_field("new_state", 32'(want.new_state), 32'(got.new_state));
				end
			end
			event_taken = start && !busy;
			if (event_taken) begin
				want = tag_update(req_type, line_addr, fill_shared);
				owed_outcomes = {owed_outcomes, want};
			end
			quiet_cycles = (event_taken || done) ? 0 : quiet_cycles + 1;
		end
	end

	// Watchdog: a run that stops moving is a failure.
	always @(posedge clk) begin
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		mesi_pkg::tag_t pool [6];
		mesi_pkg::set_t hot_sets [4];
		mesi_pkg::set_t s;
		mesi_pkg::tag_t t;
		int             pick;
		mesi_pkg::req_t req;
		logic [31:0]    addr;

		for (int i = 0; i < mesi_pkg::NUM_SETS; i++) begin
			for (int w = 0; w < mesi_pkg::NUM_WAYS; w++) begin
				line_mesi[i][w] = mesi_pkg::ST_INVALID;
				lru_rank[i][w]  = mesi_pkg::way_t'(w);
			end
		end

		// Directed part. Misses on an empty cache at both address extremes.
		push_event(mesi_pkg::REQ_READ, 32'h0000_0000, 1'b0, 1'b0);
		push_event(mesi_pkg::REQ_OTHER, 32'hFFFF_FFFF, 1'b1, 1'b0);
		// Fill every way of one set, mixing Shared and Exclusive installs.
		push_event(mesi_pkg::REQ_FILL, line_of(20'h11111, 6'd5), 1'b0, 1'b0);
		push_event(mesi_pkg::REQ_FILL, line_of(20'h22222, 6'd5) | 32'h15, 1'b1, 1'b0);
		push_event(mesi_pkg::REQ_FILL, line_of(20'h33333, 6'd5), 1'b0, 1'b0);
		push_event(mesi_pkg::REQ_FILL, line_of(20'h44444, 6'd5) | 32'h3F, 1'b1, 1'b0);
		// Snooped read hit on an Exclusive line, offset bits set: it turns Shared.
		push_event(mesi_pkg::REQ_READ, line_of(20'h33333, 6'd5) | 32'h2A, 1'b1, 1'b0);
		// Other snooped message on a hit: only the LRU order moves.
		push_event(mesi_pkg::REQ_OTHER, line_of(20'h44444, 6'd5), 1'b0, 1'b0);
		// Snooped read hit on a line that is already Shared.
		push_event(mesi_pkg::REQ_READ, line_of(20'h22222, 6'd5), 1'b0, 1'b0);
		// Set full: this fill evicts the least recently used way.
		push_event(mesi_pkg::REQ_FILL, line_of(20'h55555, 6'd5), 1'b1, 1'b0);
		// Snooped invalidate hit, then a fill that must reuse exactly that invalid way.
		push_event(mesi_pkg::REQ_INVAL, line_of(20'h33333, 6'd5) | 32'h01, 1'b0, 1'b0);
		push_event(mesi_pkg::REQ_FILL, line_of(20'h66666, 6'd5), 1'b0, 1'b0);
		// The evicted and the invalidated lines now miss.
		push_event(mesi_pkg::REQ_READ, line_of(20'h11111, 6'd5), 1'b0, 1'b0);
		push_event(mesi_pkg::REQ_INVAL, line_of(20'h33333, 6'd5), 1'b0, 1'b0);
		// Extreme lines: all ones in the last set, all zeros in set 0.
		push_event(mesi_pkg::REQ_FILL, 32'hFFFF_FFFF, 1'b1, 1'b0);
		push_event(mesi_pkg::REQ_FILL, 32'h0000_0000, 1'b0, 1'b0);
		push_event(mesi_pkg::REQ_READ, 32'hFFFF_FFC0, 1'b0, 1'b0);
		push_event(mesi_pkg::REQ_OTHER, 32'h0000_003F, 1'b1, 1'b0);
		push_event(mesi_pkg::REQ_INVAL, 32'h0000_0020, 1'b0, 1'b0);
		push_event(mesi_pkg::REQ_OTHER, 32'h0000_0000, 1'b0, 1'b0);
		// Same set, other tag: a miss even though the set holds valid lines.
		push_event(mesi_pkg::REQ_INVAL, 32'hFFFF_E000 | 32'h0FC0, 1'b0, 1'b0);

		// Random part. Most events go to a few hot sets with a small pool of tags, so that
		// snoops hit and fills run into full sets; the rest is spread over the whole space.
		pool     = '{20'h00000, 20'hFFFFF, 20'h12345, 20'hABCDE, 20'h55555, 20'hAAAAA};
		hot_sets = '{6'd0, 6'd21, 6'd42, 6'd63};
		for (int n = 0; n < RANDOM_COUNT; n++) begin
			s = ($urandom_range(0, 99) < 70) ? hot_sets[2'($urandom_range(0, 3))]
				: mesi_pkg::set_t'($urandom_range(0, mesi_pkg::NUM_SETS - 1));
			t = ($urandom_range(0, 99) < 75) ? pool[3'($urandom_range(0, 5))]
				: mesi_pkg::tag_t'($urandom());
			pick = $urandom_range(0, 99);
			if (pick < 40)
				req = mesi_pkg::REQ_FILL;
			else if (pick < 65)
				req = mesi_pkg::REQ_READ;
			else if (pick < 85)
				req = mesi_pkg::REQ_INVAL;
			else
				req = mesi_pkg::REQ_OTHER;
			addr = line_of(t, s) | 32'($urandom_range(0, mesi_pkg::LINE_BYTES - 1));
			// Now and then an event with no structure at all.
			if ($urandom_range(0, 9) == 0) begin
				req  = mesi_pkg::req_t'($urandom_range(0, 3));
				addr = $urandom();
			end
			// The first random event and one in the middle wait for the block to drain.
			push_event(req, addr, 1'($urandom_range(0, 1)), n == 0 || n == RANDOM_COUNT / 2);
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (bus_events.size() == 0 && owed_outcomes.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && owed_outcomes.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
